// File: rtl/ipbf_pkg.sv
// ----------------------------------------------------------------------------
// ipbf_pkg
// shared types, codes and sizes for the ip/port blocklist filter
// ----------------------------------------------------------------------------
package ipbf_pkg;

  localparam int ADDR_ENTRIES = 64;
  localparam int PORT_ENTRIES = 64;
  localparam int ADDR_AGE_W   = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
  localparam int PORT_AGE_W   = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

  localparam int POS_W        = 7;
  localparam logic [POS_W-1:0] POS_MAX = 7'd127;

  localparam logic [15:0] ETYPE_V4  = 16'h0800;
  localparam logic [15:0] ETYPE_V6  = 16'h86DD;
  localparam logic [3:0]  IHL_MASK  = 4'hf;
  localparam logic [7:0]  PROTO_TCP = 8'd6;
  localparam logic [7:0]  PROTO_UDP = 8'd17;

  localparam logic [2:0] FUNC_FRAME    = 3'd0;
  localparam logic [2:0] FUNC_ADDR_SET = 3'd1;
  localparam logic [2:0] FUNC_ADDR_DEL = 3'd2;
  localparam logic [2:0] FUNC_PORT_SET = 3'd3;
  localparam logic [2:0] FUNC_PORT_DEL = 3'd4;

  localparam logic [2:0] CAUSE_PASS   = 3'd0;
  localparam logic [2:0] CAUSE_ADDR   = 3'd1;
  localparam logic [2:0] CAUSE_PORT   = 3'd2;
  localparam logic [2:0] CAUSE_NOT_IP = 3'd3;
  localparam logic [2:0] CAUSE_TRUNC  = 3'd4;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [63:0] addr_key_upper;
    logic [63:0] addr_key_lower;
    logic [15:0] port_key;
    logic [7:0]  entry_value;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic [2:0]  cause;
    logic [63:0] dropped_total;
    logic [63:0] passed_total;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_JUDGE,
    JOB_ADDR_SET,
    JOB_ADDR_DEL,
    JOB_PORT_SET,
    JOB_PORT_DEL
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        fixed;
    logic [2:0]  fixed_cause;
    logic        l4_short;
    logic [63:0] key_upper;
    logic [63:0] key_lower;
    logic [15:0] port;
    logic [7:0]  value;
  } job_t;

endpackage

// File: rtl/ipbf_front.sv
// ----------------------------------------------------------------------------
// ipbf_front
// parses frame bytes into header fields and issues one job per frame end
// or table command
// ----------------------------------------------------------------------------
module ipbf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_take,
  input  ipbf_pkg::in_item_t in_data,
  output logic              push,
  output ipbf_pkg::job_t    job
);

  logic [ipbf_pkg::POS_W-1:0] pos_r, pos_nxt, len;
  logic [15:0] etype_r, etype_cur;
  logic [3:0]  ihl_r, ihl_cur;
  logic [7:0]  proto4_r, proto4_cur, proto6_r, proto6_cur, proto;
  logic [31:0] v4addr_r, v4addr_cur;
  logic [63:0] v6up_r, v6up_cur, v6lo_r, v6lo_cur;
  logic [15:0] dport_r, dport_cur;
  logic [7:0]  b, tpos, need;
  logic        byte_in, is_v4, is_v6, is_tcp, is_udp;

  assign b       = in_data.frame_byte;
  assign byte_in = in_take && (in_data.func == ipbf_pkg::FUNC_FRAME);

  always_comb begin
    etype_cur  = etype_r;
    ihl_cur    = ihl_r;
    proto4_cur = proto4_r;
    proto6_cur = proto6_r;
    v4addr_cur = v4addr_r;
    v6up_cur   = v6up_r;
    v6lo_cur   = v6lo_r;
    if (byte_in) begin
      if (pos_r == 7'd12) etype_cur[15:8] = b;
      if (pos_r == 7'd13) etype_cur[7:0] = b;
      if (pos_r == 7'd14) ihl_cur = b[3:0] & ipbf_pkg::IHL_MASK;
      if (pos_r == 7'd23) proto4_cur = b;
      if (pos_r == 7'd20) proto6_cur = b;
      for (int k = 0; k < 4; k++) begin
        if (pos_r == 7'(30 + k)) v4addr_cur[31-8*k -: 8] = b;
      end
      for (int k = 0; k < 8; k++) begin
        if (pos_r == 7'(38 + k)) v6up_cur[63-8*k -: 8] = b;
        if (pos_r == 7'(46 + k)) v6lo_cur[63-8*k -: 8] = b;
      end
    end
  end

  assign is_v4 = (etype_cur == ipbf_pkg::ETYPE_V4);
  assign is_v6 = (etype_cur == ipbf_pkg::ETYPE_V6);
  assign tpos  = is_v6 ? 8'd54 : 8'd14 + {2'b00, ihl_cur, 2'b00};

  always_comb begin
    dport_cur = dport_r;
    if (byte_in) begin
      if ({1'b0, pos_r} == tpos + 8'd2) dport_cur[15:8] = b;
      if ({1'b0, pos_r} == tpos + 8'd3) dport_cur[7:0] = b;
    end
  end

  assign proto  = is_v6 ? proto6_cur : proto4_cur;
  assign is_tcp = (proto == ipbf_pkg::PROTO_TCP);
  assign is_udp = (proto == ipbf_pkg::PROTO_UDP);
  assign need   = tpos + (is_tcp ? 8'd20 : 8'd8);
  assign len    = (pos_r == ipbf_pkg::POS_MAX) ? pos_r : pos_r + 7'd1;

  always_comb begin
    pos_nxt = pos_r;
    if (byte_in) pos_nxt = in_data.frame_end ? '0 : len;
  end

  always_comb begin
    job             = '0;
    job.kind        = ipbf_pkg::JOB_JUDGE;
    job.fixed_cause = ipbf_pkg::CAUSE_PASS;
    job.value       = in_data.entry_value;
    push            = 1'b0;
    case (in_data.func)
      ipbf_pkg::FUNC_FRAME: begin
        push          = in_take && in_data.frame_end;
        job.key_upper = is_v6 ? v6up_cur : {v4addr_cur, 32'd0};
        job.key_lower = is_v6 ? v6lo_cur : 64'd0;
        job.l4_short  = (is_tcp || is_udp) && ({1'b0, len} < need);
        job.port      = (is_tcp || is_udp) ? dport_cur : 16'd0;
        if (len < 7'd14) begin
          job.fixed = 1'b1; job.fixed_cause = ipbf_pkg::CAUSE_TRUNC;
        end else if (!is_v4 && !is_v6) begin
          job.fixed = 1'b1; job.fixed_cause = ipbf_pkg::CAUSE_NOT_IP;
        end else if ((is_v4 && len < 7'd34) || (is_v6 && len < 7'd54)) begin
          job.fixed = 1'b1; job.fixed_cause = ipbf_pkg::CAUSE_TRUNC;
        end
      end
      ipbf_pkg::FUNC_ADDR_SET, ipbf_pkg::FUNC_ADDR_DEL,
      ipbf_pkg::FUNC_PORT_SET, ipbf_pkg::FUNC_PORT_DEL: begin
        push          = in_take;
        job.key_upper = in_data.addr_key_upper;
        job.key_lower = in_data.addr_key_lower;
        job.port      = in_data.port_key;
        case (in_data.func)
          ipbf_pkg::FUNC_ADDR_SET: job.kind = ipbf_pkg::JOB_ADDR_SET;
          ipbf_pkg::FUNC_ADDR_DEL: job.kind = ipbf_pkg::JOB_ADDR_DEL;
          ipbf_pkg::FUNC_PORT_SET: job.kind = ipbf_pkg::JOB_PORT_SET;
          default:                 job.kind = ipbf_pkg::JOB_PORT_DEL;
        endcase
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      etype_r  <= '0;
      ihl_r    <= '0;
      proto4_r <= '0;
      proto6_r <= '0;
      v4addr_r <= '0;
      v6up_r   <= '0;
      v6lo_r   <= '0;
      dport_r  <= '0;
    end else if (byte_in) begin
      etype_r  <= etype_cur;
      ihl_r    <= ihl_cur;
      proto4_r <= proto4_cur;
      proto6_r <= proto6_cur;
      v4addr_r <= v4addr_cur;
      v6up_r   <= v6up_cur;
      v6lo_r   <= v6lo_cur;
      dport_r  <= dport_cur;
    end
  end

endmodule

// File: rtl/ipbf_queue.sv
// ----------------------------------------------------------------------------
// ipbf_queue
// short job queue between the parser and the table engine
// ----------------------------------------------------------------------------
module ipbf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ipbf_pkg::job_t wdata,
  input  logic           pop,
  output ipbf_pkg::job_t rdata,
  output logic           full,
  output logic           empty
);

  ipbf_pkg::job_t mem_r [ipbf_pkg::QUEUE_DEPTH];
  logic [ipbf_pkg::QUEUE_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [ipbf_pkg::QUEUE_PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (ipbf_pkg::QUEUE_PTR_W+1)'(ipbf_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (ipbf_pkg::QUEUE_PTR_W+1)'(push) - (ipbf_pkg::QUEUE_PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// File: rtl/ipbf_back.sv
// ----------------------------------------------------------------------------
// ipbf_back
// lru address and port tables, verdict, counters and output register
// ----------------------------------------------------------------------------
module ipbf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  input  ipbf_pkg::job_t     job,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ipbf_pkg::out_item_t out_data
);

  localparam int NA = ipbf_pkg::ADDR_ENTRIES;
  localparam int NP = ipbf_pkg::PORT_ENTRIES;
  localparam int AW = ipbf_pkg::ADDR_AGE_W;
  localparam int PW = ipbf_pkg::PORT_AGE_W;

  logic [NA-1:0] a_valid_r, a_valid_nxt, a_hit, a_blk, a_free, a_evict, a_alloc;
  logic [AW-1:0] a_age_r [NA];
  logic [AW-1:0] a_age_nxt [NA];
  logic [63:0]   a_up_r [NA];
  logic [63:0]   a_lo_r [NA];
  logic [7:0]    a_val_r [NA];
  logic [AW-1:0] a_hit_age;

  logic [NP-1:0] p_valid_r, p_valid_nxt, p_hit, p_blk, p_free, p_evict, p_alloc;
  logic [PW-1:0] p_age_r [NP];
  logic [PW-1:0] p_age_nxt [NP];
  logic [15:0]   p_key_r [NP];
  logic [7:0]    p_val_r [NP];
  logic [PW-1:0] p_hit_age;

  logic a_touch, a_new, a_rm, a_setv, p_touch, p_new, p_rm, p_setv;
  logic a_any, a_blocked, p_any, p_blocked, go, judge;
  logic [2:0] cause;
  logic [63:0] drop_r, drop_nxt, pass_r, pass_nxt;
  logic out_valid_r, out_valid_nxt;
  ipbf_pkg::out_item_t out_r, out_nxt;

  assign go    = job_valid && (!out_valid_r || out_ready);
  assign pop   = go;
  assign judge = (job.kind == ipbf_pkg::JOB_JUDGE);

  always_comb begin
    a_hit_age = '0;
    for (int i = 0; i < NA; i++) begin
      a_hit[i] = a_valid_r[i] && (a_up_r[i] == job.key_upper) && (a_lo_r[i] == job.key_lower);
      a_blk[i] = a_hit[i] && (a_val_r[i] != 8'd0);
      a_evict[i] = a_valid_r[i] && (a_age_r[i] == AW'(NA - 1));
      if (a_hit[i]) a_hit_age = a_hit_age | a_age_r[i];
    end
    p_hit_age = '0;
    for (int i = 0; i < NP; i++) begin
      p_hit[i] = p_valid_r[i] && (p_key_r[i] == job.port);
      p_blk[i] = p_hit[i] && (p_val_r[i] != 8'd0);
      p_evict[i] = p_valid_r[i] && (p_age_r[i] == PW'(NP - 1));
      if (p_hit[i]) p_hit_age = p_hit_age | p_age_r[i];
    end
  end

  assign a_any     = |a_hit;
  assign a_blocked = |a_blk;
  assign p_any     = |p_hit;
  assign p_blocked = |p_blk;
  assign a_free    = ~a_valid_r & (a_valid_r + NA'(1));
  assign p_free    = ~p_valid_r & (p_valid_r + NP'(1));
  assign a_alloc   = (&a_valid_r) ? a_evict : a_free;
  assign p_alloc   = (&p_valid_r) ? p_evict : p_free;

  always_comb begin
    a_touch = 1'b0; a_new = 1'b0; a_rm = 1'b0; a_setv = 1'b0;
    p_touch = 1'b0; p_new = 1'b0; p_rm = 1'b0; p_setv = 1'b0;
    cause   = ipbf_pkg::CAUSE_PASS;
    case (job.kind)
      ipbf_pkg::JOB_JUDGE: begin
        if (job.fixed) begin
          cause = job.fixed_cause;
        end else begin
          a_touch = a_any;
          if (a_blocked) begin
            cause = ipbf_pkg::CAUSE_ADDR;
          end else if (job.l4_short) begin
            cause = ipbf_pkg::CAUSE_TRUNC;
          end else if (job.port != 16'd0 && p_any) begin
            p_touch = 1'b1;
            if (p_blocked) cause = ipbf_pkg::CAUSE_PORT;
          end
        end
      end
      ipbf_pkg::JOB_ADDR_SET: begin
        a_touch = a_any; a_setv = a_any; a_new = !a_any;
      end
      ipbf_pkg::JOB_ADDR_DEL: a_rm = a_any;
      ipbf_pkg::JOB_PORT_SET: begin
        p_touch = p_any; p_setv = p_any; p_new = !p_any;
      end
      ipbf_pkg::JOB_PORT_DEL: p_rm = p_any;
      default: cause = ipbf_pkg::CAUSE_PASS;
    endcase
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    for (int i = 0; i < NA; i++) begin
      a_age_nxt[i] = a_age_r[i];
      if (a_touch) begin
        if (a_hit[i]) a_age_nxt[i] = '0;
        else if (a_valid_r[i] && a_age_r[i] < a_hit_age) a_age_nxt[i] = a_age_r[i] + AW'(1);
      end
      if (a_new) begin
        if (a_alloc[i]) begin
          a_valid_nxt[i] = 1'b1;
          a_age_nxt[i]   = '0;
        end else if (a_valid_r[i]) begin
          a_age_nxt[i] = a_age_r[i] + AW'(1);
        end
      end
      if (a_rm) begin
        if (a_hit[i]) begin
          a_valid_nxt[i] = 1'b0;
          a_age_nxt[i]   = '0;
        end else if (a_valid_r[i] && a_age_r[i] > a_hit_age) begin
          a_age_nxt[i] = a_age_r[i] - AW'(1);
        end
      end
    end
    p_valid_nxt = p_valid_r;
    for (int i = 0; i < NP; i++) begin
      p_age_nxt[i] = p_age_r[i];
      if (p_touch) begin
        if (p_hit[i]) p_age_nxt[i] = '0;
        else if (p_valid_r[i] && p_age_r[i] < p_hit_age) p_age_nxt[i] = p_age_r[i] + PW'(1);
      end
      if (p_new) begin
        if (p_alloc[i]) begin
          p_valid_nxt[i] = 1'b1;
          p_age_nxt[i]   = '0;
        end else if (p_valid_r[i]) begin
          p_age_nxt[i] = p_age_r[i] + PW'(1);
        end
      end
      if (p_rm) begin
        if (p_hit[i]) begin
          p_valid_nxt[i] = 1'b0;
          p_age_nxt[i]   = '0;
        end else if (p_valid_r[i] && p_age_r[i] > p_hit_age) begin
          p_age_nxt[i] = p_age_r[i] - PW'(1);
        end
      end
    end
  end

  always_comb begin
    drop_nxt      = drop_r;
    pass_nxt      = pass_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (go && judge) begin
      if (cause == ipbf_pkg::CAUSE_ADDR || cause == ipbf_pkg::CAUSE_PORT) begin
        drop_nxt = drop_r + 64'd1;
      end else if (cause == ipbf_pkg::CAUSE_PASS) begin
        pass_nxt = pass_r + 64'd1;
      end
      out_nxt.verdict       = (cause == ipbf_pkg::CAUSE_ADDR || cause == ipbf_pkg::CAUSE_PORT);
      out_nxt.cause         = cause;
      out_nxt.dropped_total = drop_nxt;
      out_nxt.passed_total  = pass_nxt;
      out_valid_nxt         = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= '0;
      p_valid_r   <= '0;
      drop_r      <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NA; i++) a_age_r[i] <= '0;
      for (int i = 0; i < NP; i++) p_age_r[i] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (go) begin
        a_valid_r <= a_valid_nxt;
        p_valid_r <= p_valid_nxt;
        drop_r    <= drop_nxt;
        pass_r    <= pass_nxt;
        for (int i = 0; i < NA; i++) a_age_r[i] <= a_age_nxt[i];
        for (int i = 0; i < NP; i++) p_age_r[i] <= p_age_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    for (int i = 0; i < NA; i++) begin
      if (go && a_new && a_alloc[i]) begin
        a_up_r[i]  <= job.key_upper;
        a_lo_r[i]  <= job.key_lower;
        a_val_r[i] <= job.value;
      end else if (go && a_setv && a_hit[i]) begin
        a_val_r[i] <= job.value;
      end
    end
    for (int i = 0; i < NP; i++) begin
      if (go && p_new && p_alloc[i]) begin
        p_key_r[i] <= job.port;
        p_val_r[i] <= job.value;
      end else if (go && p_setv && p_hit[i]) begin
        p_val_r[i] <= job.value;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_addr_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> $onehot0(a_hit))
    else $error("address table holds a key twice");
  a_port_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> $onehot0(p_hit))
    else $error("port table holds a key twice");
  a_addr_evict_one: assert property (@(posedge clk) disable iff (!rst_n)
    (&a_valid_r) |-> $onehot(a_evict))
    else $error("full address table has no single oldest entry");
  a_port_evict_one: assert property (@(posedge clk) disable iff (!rst_n)
    (&p_valid_r) |-> $onehot(p_evict))
    else $error("full port table has no single oldest entry");
`endif

endmodule

// File: rtl/ip_port_blocklist_filter.sv
// ----------------------------------------------------------------------------
// ip_port_blocklist_filter
// per-frame pass/drop verdict from ipv4/ipv6 destination address and
// tcp/udp destination port lru blocklists
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  in      | in_valid, in_ready, in_data    | frame byte or table command
//  out     | out_valid, out_ready, out_data | one verdict per frame end
//
// one transaction per cycle on the input while the job queue is not full:
// header fields are captured as the bytes stream past, so each frame end or
// command becomes one queued job. the table engine retires one job per cycle
// unless the output waits on out_ready; the lookup, lru update and counter update
// all happen in that single cycle. a four-entry job queue and the output
// register decouple the two sides. synchronous reset clears tables to empty, counters to zero.
module ip_port_blocklist_filter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipbf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ipbf_pkg::out_item_t out_data
);

  logic           in_take, push, pop, full, empty;
  ipbf_pkg::job_t job_in, job_out;

  assign in_ready = !full;
  assign in_take  = in_valid && in_ready;

  ipbf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_data (in_data),
    .push    (push),
    .job     (job_in)
  );

  ipbf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .pop   (pop),
    .rdata (job_out),
    .full  (full),
    .empty (empty)
  );

  ipbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!empty),
    .job       (job_out),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
